/* design/pcp_pkg.sv */
// Shared constants, types and codes for the Pearson correlation pairs unit.
package pcp_pkg;

    // Input sample and set capacity
    localparam int VALUE_W   = 16;
    localparam int MAX_PAIRS = 4096;

    // Accumulator widths
    localparam int CNT_W = 13;
    localparam int SUM_W = 28;
    localparam int SQ_W  = 44;

    // Back-end arithmetic widths: variances and covariance, their products
    localparam int VAR_W  = 56;
    localparam int PROD_W = 2 * VAR_W;

    // Result format: 16 fraction bits, quotient holds r^2 * 2^32
    localparam int FRAC_W  = 16;
    localparam int QUO_W   = 2 * FRAC_W + 1;
    localparam int ROOT_W  = FRAC_W + 1;
    localparam int COEF_W  = FRAC_W + 2;
    localparam int STAT_W  = 2;

    // Divider step counter
    localparam int DIV_CNT_W = $clog2(QUO_W);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(QUO_W - 1);

    // Set queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_NO_PAIRS = 2'd1,
        ST_ZERO_VAR = 2'd2,
        ST_OVERFLOW = 2'd3
    } status_t;

    // Finished accumulator set handed from front to back
    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [SUM_W-1:0] sum_a;
        logic [SUM_W-1:0] sum_b;
        logic [SQ_W-1:0]  sq_a;
        logic [SQ_W-1:0]  sq_b;
        logic [SQ_W-1:0]  sum_ab;
        logic             overflow;
    } snap_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mul_stat_t;

endpackage

/* design/pcp_pair_if.sv */
// Valid/ready channel carrying one sample pair per item.
interface pcp_pair_if import pcp_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value_a;
    logic [VALUE_W-1:0] value_b;
    logic               last_pair;

    modport source (output valid, value_a, value_b, last_pair, input ready);
    modport sink   (input valid, value_a, value_b, last_pair, output ready);
endinterface

/* design/pcp_result_if.sv */
// Valid/ready channel carrying one correlation result per item.
interface pcp_result_if import pcp_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [COEF_W-1:0] coefficient;
    logic [STAT_W-1:0]        status;
    logic [CNT_W-1:0]         pair_count;

    modport source (output valid, coefficient, status, pair_count, input ready);
    modport sink   (input valid, coefficient, status, pair_count, output ready);
endinterface

/* design/pearson_correlation_pairs_unit.sv */
// Pearson correlation unit: streams value pairs, reports one coefficient per set.
//
// pairs (sink): one item per pair (value_a, value_b, last_pair). Pairs are
// taken one per cycle unless the queue is full. The pair with last_pair set
// closes the set; its accumulated count, sums, squares and product sum move into
// a two-deep set queue and the accumulators clear the same cycle, so the next
// set can stream in at once. Pairs past 4096 in a set are dropped and flagged.
// results (source): one item per set: coefficient (r * 65536, truncated
// toward zero), status and pair_count, held in an output register.
// Once the sets ahead are done, each set is worked by the shared shift-add
// multiplier (up to eight products, one bit of the shorter operand per
// cycle), a 33-step restoring divider and a 17-step square root. Sets are
// finished one at a time in that order; pairs keep flowing until two sets
// wait in the queue behind the one in progress.
// A stalled receiver holds the result register; the back end finishes the
// next set and waits for the register to free.
// Reset (rst_n low, asynchronous) clears the accumulators, the queue and
// the sequencer; no result is pending afterwards.
module pearson_correlation_pairs_unit import pcp_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    pcp_pair_if.sink     pairs,
    pcp_result_if.source results
);

    fifo_stat_t qstat;
    logic       push;
    snap_t      push_data;
    logic       pop;
    snap_t      pop_data;

    pcp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .pairs     (pairs),
        .qstat     (qstat),
        .push      (push),
        .push_data (push_data)
    );

    pcp_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .stat      (qstat)
    );

    pcp_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .qstat    (qstat),
        .pop_data (pop_data),
        .pop      (pop),
        .results  (results)
    );

endmodule

/* design/pcp_front.sv */
// Front end: accepts pairs, accumulates count, sums, squares and products.
module pcp_front import pcp_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    pcp_pair_if.sink   pairs,
    input  fifo_stat_t qstat,
    output logic       push,
    output snap_t      push_data
);

    logic [CNT_W-1:0] count_reg, count_next;
    logic [SUM_W-1:0] sum_a_reg, sum_a_next;
    logic [SUM_W-1:0] sum_b_reg, sum_b_next;
    logic [SQ_W-1:0]  sq_a_reg, sq_a_next;
    logic [SQ_W-1:0]  sq_b_reg, sq_b_next;
    logic [SQ_W-1:0]  sum_ab_reg, sum_ab_next;
    logic             ovf_reg, ovf_next;

    logic                 accept;
    logic                 room;
    logic [2*VALUE_W-1:0] a_sq;
    logic [2*VALUE_W-1:0] b_sq;
    logic [2*VALUE_W-1:0] ab;

    // A pair may always be taken unless the set queue is full
    assign pairs.ready = !qstat.full;
    assign accept      = pairs.valid && pairs.ready;
    assign room        = count_reg < CNT_W'(MAX_PAIRS);

    // Per-pair products
    assign a_sq = pairs.value_a * pairs.value_a;
    assign b_sq = pairs.value_b * pairs.value_b;
    assign ab   = pairs.value_a * pairs.value_b;

    // Accumulate unless the set is at capacity
    always_comb
    begin
        count_next  = count_reg;
        sum_a_next  = sum_a_reg;
        sum_b_next  = sum_b_reg;
        sq_a_next   = sq_a_reg;
        sq_b_next   = sq_b_reg;
        sum_ab_next = sum_ab_reg;
        ovf_next    = ovf_reg;
        if (room)
        begin
            count_next  = count_reg + CNT_W'(1);
            sum_a_next  = sum_a_reg + SUM_W'(pairs.value_a);
            sum_b_next  = sum_b_reg + SUM_W'(pairs.value_b);
            sq_a_next   = sq_a_reg + SQ_W'(a_sq);
            sq_b_next   = sq_b_reg + SQ_W'(b_sq);
            sum_ab_next = sum_ab_reg + SQ_W'(ab);
        end
        else
        begin
            ovf_next = 1'b1;
        end
    end

    // Last pair closes the set and hands it to the back end
    assign push               = accept && pairs.last_pair;
    assign push_data.count    = count_next;
    assign push_data.sum_a    = sum_a_next;
    assign push_data.sum_b    = sum_b_next;
    assign push_data.sq_a     = sq_a_next;
    assign push_data.sq_b     = sq_b_next;
    assign push_data.sum_ab   = sum_ab_next;
    assign push_data.overflow = ovf_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            sum_a_reg  <= '0;
            sum_b_reg  <= '0;
            sq_a_reg   <= '0;
            sq_b_reg   <= '0;
            sum_ab_reg <= '0;
            ovf_reg    <= 1'b0;
        end
        else if (accept)
        begin
            if (pairs.last_pair)
            begin
                count_reg  <= '0;
                sum_a_reg  <= '0;
                sum_b_reg  <= '0;
                sq_a_reg   <= '0;
                sq_b_reg   <= '0;
                sum_ab_reg <= '0;
                ovf_reg    <= 1'b0;
            end
            else
            begin
                count_reg  <= count_next;
                sum_a_reg  <= sum_a_next;
                sum_b_reg  <= sum_b_next;
                sq_a_reg   <= sq_a_next;
                sq_b_reg   <= sq_b_next;
                sum_ab_reg <= sum_ab_next;
                ovf_reg    <= ovf_next;
            end
        end
    end

endmodule

/* design/pcp_fifo.sv */
// Short queue of finished accumulator sets between front and back.
module pcp_fifo import pcp_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  snap_t      push_data,
    input  logic       pop,
    output snap_t      pop_data,
    output fifo_stat_t stat
);

    snap_t             entry [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] fill_reg;

    assign stat.full  = fill_reg == QCNT_W'(QDEPTH);
    assign stat.empty = fill_reg == '0;
    assign pop_data   = entry[rd_ptr_reg];

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry[wr_ptr_reg] <= push_data;
        end
    end

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0
                                                                  : wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0
                                                                  : rd_ptr_reg + QPTR_W'(1);
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + QCNT_W'(1);
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - QCNT_W'(1);
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) push |-> !stat.full)
        else $error("set queue written while full");
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> !stat.empty)
        else $error("set queue read while empty");

endmodule

/* design/pcp_mul.sv */
// Shift-add multiplier: one multiplier bit per cycle, stops early when done.
module pcp_mul import pcp_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [VAR_W-1:0]  op_a,
    input  logic [VAR_W-1:0]  op_b,
    output logic [PROD_W-1:0] product,
    output mul_stat_t         stat
);

    logic              run_reg;
    logic [PROD_W-1:0] a_reg;
    logic [VAR_W-1:0]  b_reg;
    logic [PROD_W-1:0] acc_reg;

    assign stat.busy = run_reg;
    assign stat.done = run_reg && (b_reg == '0);
    assign product   = acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
        end
        else if (start)
        begin
            run_reg <= 1'b1;
        end
        else if (stat.done)
        begin
            run_reg <= 1'b0;
        end
    end

    // Operand shifting and partial product accumulation
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= PROD_W'(op_a);
            b_reg   <= op_b;
            acc_reg <= '0;
        end
        else if (run_reg && (b_reg != '0))
        begin
            if (b_reg[0])
            begin
                acc_reg <= acc_reg + a_reg;
            end
            a_reg <= a_reg << 1;
            b_reg <= b_reg >> 1;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) start |-> !run_reg)
        else $error("multiplier started while busy");

endmodule

/* design/pcp_back.sv */
// Back end: forms variances and covariance, divides and takes the root per set.
module pcp_back import pcp_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  fifo_stat_t  qstat,
    input  snap_t       pop_data,
    output logic        pop,
    pcp_result_if.source results
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_GO,
        S_MUL_WAIT,
        S_DIV,
        S_SQRT,
        S_FINISH
    } state_t;

    typedef enum logic [2:0] {
        OP_NQA,
        OP_SASA,
        OP_NQB,
        OP_SBSB,
        OP_NP,
        OP_SASB,
        OP_VAVB,
        OP_CC
    } mul_op_t;

    state_t                   state_reg;
    mul_op_t                  op_reg;
    logic [DIV_CNT_W-1:0]     div_cnt_reg;
    logic                     out_valid_reg;
    logic signed [COEF_W-1:0] coef_reg;
    status_t                  status_reg;
    logic [CNT_W-1:0]         count_reg;

    // Datapath registers
    snap_t             snap_reg;
    logic [VAR_W-1:0]  t0_reg;
    logic [VAR_W-1:0]  va_reg;
    logic [VAR_W-1:0]  vb_reg;
    logic [VAR_W-1:0]  cmag_reg;
    logic              neg_reg;
    logic [PROD_W-1:0] d_reg;
    logic [PROD_W-1:0] rem_reg;
    logic [QUO_W-1:0]  dsh_reg;
    logic [QUO_W-1:0]  quo_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [ROOT_W-1:0] rbit_reg;

    // Multiplier hookup
    logic              mul_start;
    logic [VAR_W-1:0]  mul_a;
    logic [VAR_W-1:0]  mul_b;
    logic [PROD_W-1:0] mul_prod;
    mul_stat_t         mstat;
    logic [VAR_W-1:0]  prod_lo;

    // Combinational helpers
    logic [VAR_W-1:0]    diff_lo;
    logic                neg_now;
    logic [VAR_W-1:0]    cmag_now;
    logic                zero_var;
    logic [PROD_W:0]     div_trial;
    logic [PROD_W+1:0]   div_diff;
    logic                div_take;
    logic [ROOT_W-1:0]   root_trial;
    logic [2*ROOT_W-1:0] root_sq;
    logic                root_fits;
    logic signed [COEF_W-1:0] root_ext;
    logic signed [COEF_W-1:0] coef_now;
    status_t             status_now;
    logic                out_free;

    pcp_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .product (mul_prod),
        .stat    (mstat)
    );

    assign mul_start = state_reg == S_MUL_GO;
    assign prod_lo   = mul_prod[VAR_W-1:0];
    assign pop       = (state_reg == S_IDLE) && !qstat.empty;

    // Operand select; the shorter operand goes to the shifted side
    always_comb
    begin
        unique case (op_reg)
            OP_NQA:
            begin
                mul_a = VAR_W'(snap_reg.sq_a);
                mul_b = VAR_W'(snap_reg.count);
            end
            OP_SASA:
            begin
                mul_a = VAR_W'(snap_reg.sum_a);
                mul_b = VAR_W'(snap_reg.sum_a);
            end
            OP_NQB:
            begin
                mul_a = VAR_W'(snap_reg.sq_b);
                mul_b = VAR_W'(snap_reg.count);
            end
            OP_SBSB:
            begin
                mul_a = VAR_W'(snap_reg.sum_b);
                mul_b = VAR_W'(snap_reg.sum_b);
            end
            OP_NP:
            begin
                mul_a = VAR_W'(snap_reg.sum_ab);
                mul_b = VAR_W'(snap_reg.count);
            end
            OP_SASB:
            begin
                mul_a = VAR_W'(snap_reg.sum_a);
                mul_b = VAR_W'(snap_reg.sum_b);
            end
            OP_VAVB:
            begin
                mul_a = va_reg;
                mul_b = vb_reg;
            end
            OP_CC:
            begin
                mul_a = cmag_reg;
                mul_b = cmag_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // n*Q - S*S and the signed covariance magnitude
    assign diff_lo  = t0_reg - prod_lo;
    assign neg_now  = t0_reg < prod_lo;
    assign cmag_now = neg_now ? (prod_lo - t0_reg) : diff_lo;
    assign zero_var = (va_reg == '0) || (vb_reg == '0);

    // Restoring division step: c^2 * 2^32 / (vA * vB)
    assign div_trial = {rem_reg, dsh_reg[QUO_W-1]};
    assign div_diff  = {1'b0, div_trial} - {2'b00, d_reg};
    assign div_take  = !div_diff[PROD_W+1];

    // Square root step, one result bit per cycle from the top
    assign root_trial = root_reg | rbit_reg;
    assign root_sq    = root_trial * root_trial;
    assign root_fits  = root_sq <= (2*ROOT_W)'(quo_reg);

    // Result fields
    assign root_ext = COEF_W'(root_reg);
    assign coef_now = neg_reg ? -root_ext : root_ext;
    assign out_free = !out_valid_reg || results.ready;

    always_comb
    begin
        priority if (snap_reg.overflow)
        begin
            status_now = ST_OVERFLOW;
        end
        else if (snap_reg.count == '0)
        begin
            status_now = ST_NO_PAIRS;
        end
        else if (zero_var)
        begin
            status_now = ST_ZERO_VAR;
        end
        else
        begin
            status_now = ST_OK;
        end
    end

    assign results.valid       = out_valid_reg;
    assign results.coefficient = coef_reg;
    assign results.status      = status_reg;
    assign results.pair_count  = count_reg;

    // Sequencer and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= OP_NQA;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            coef_reg      <= '0;
            status_reg    <= ST_OK;
            count_reg     <= '0;
        end
        else
        begin
            // In S_FINISH the result register is reloaded below instead
            if (results.valid && results.ready && (state_reg != S_FINISH))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (!qstat.empty)
                    begin
                        state_reg <= S_MUL_GO;
                        op_reg    <= OP_NQA;
                    end
                end
                S_MUL_GO:
                begin
                    state_reg <= S_MUL_WAIT;
                end
                S_MUL_WAIT:
                begin
                    if (mstat.done)
                    begin
                        unique case (op_reg)
                            OP_NQA:
                            begin
                                op_reg    <= OP_SASA;
                                state_reg <= S_MUL_GO;
                            end
                            OP_SASA:
                            begin
                                op_reg    <= OP_NQB;
                                state_reg <= S_MUL_GO;
                            end
                            OP_NQB:
                            begin
                                op_reg    <= OP_SBSB;
                                state_reg <= S_MUL_GO;
                            end
                            OP_SBSB:
                            begin
                                op_reg    <= OP_NP;
                                state_reg <= S_MUL_GO;
                            end
                            OP_NP:
                            begin
                                op_reg    <= OP_SASB;
                                state_reg <= S_MUL_GO;
                            end
                            OP_SASB:
                            begin
                                if (zero_var)
                                begin
                                    state_reg <= S_FINISH;
                                end
                                else
                                begin
                                    op_reg    <= OP_VAVB;
                                    state_reg <= S_MUL_GO;
                                end
                            end
                            OP_VAVB:
                            begin
                                op_reg    <= OP_CC;
                                state_reg <= S_MUL_GO;
                            end
                            OP_CC:
                            begin
                                div_cnt_reg <= '0;
                                state_reg   <= S_DIV;
                            end
                            default:
                            begin
                                state_reg <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_DIV:
                begin
                    if (div_cnt_reg == DIV_LAST)
                    begin
                        state_reg <= S_SQRT;
                    end
                    else
                    begin
                        div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
                    end
                end
                S_SQRT:
                begin
                    if (rbit_reg[0])
                    begin
                        state_reg <= S_FINISH;
                    end
                end
                S_FINISH:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        coef_reg      <= coef_now;
                        status_reg    <= status_now;
                        count_reg     <= snap_reg.count;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Arithmetic datapath
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            snap_reg <= pop_data;
        end
        if ((state_reg == S_MUL_WAIT) && mstat.done)
        begin
            unique case (op_reg)
                OP_NQA, OP_NQB, OP_NP:
                begin
                    t0_reg <= prod_lo;
                end
                OP_SASA:
                begin
                    va_reg <= diff_lo;
                end
                OP_SBSB:
                begin
                    vb_reg <= diff_lo;
                end
                OP_SASB:
                begin
                    neg_reg  <= neg_now;
                    cmag_reg <= cmag_now;
                    root_reg <= '0;
                end
                OP_VAVB:
                begin
                    d_reg <= mul_prod;
                end
                OP_CC:
                begin
                    rem_reg  <= PROD_W'(mul_prod[PROD_W-1:1]);
                    dsh_reg  <= {mul_prod[0], (QUO_W-1)'(0)};
                    quo_reg  <= '0;
                    root_reg <= '0;
                    rbit_reg <= {1'b1, (ROOT_W-1)'(0)};
                end
                default:
                begin
                    t0_reg <= t0_reg;
                end
            endcase
        end
        if (state_reg == S_DIV)
        begin
            rem_reg <= div_take ? div_diff[PROD_W-1:0] : div_trial[PROD_W-1:0];
            dsh_reg <= dsh_reg << 1;
            quo_reg <= {quo_reg[QUO_W-2:0], div_take};
        end
        if (state_reg == S_SQRT)
        begin
            if (root_fits)
            begin
                root_reg <= root_trial;
            end
            rbit_reg <= rbit_reg >> 1;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (rem_reg < d_reg))
        else $error("division remainder not below divisor");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SQRT) |-> $onehot(rbit_reg))
        else $error("root bit marker lost");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status_reg == ST_NO_PAIRS || status_reg == ST_ZERO_VAR))
        |-> (coef_reg == '0))
        else $error("nonzero coefficient on degenerate set");

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for pearson_correlation_pairs_unit: directed, long and random pair sets.
`timescale 1ns / 100ps

module tb_top;
    import pcp_pkg::*;

    localparam int WIDE       = 192;        // room for q*q*varA*varB and cov^2 * 2^32
    localparam int CYCLE_CAP  = 1_000_000;
    localparam int DRAIN      = 400;        // worst set latency plus a stalled receiver
    localparam int LONG_SET   = 200;
    localparam int RAND_ITEMS = 580;
    localparam int N_ROWS     = 20;
    localparam int IDLE_PCT   = 6;
    localparam int MAX_PRINTS = 100;

    typedef struct {
        logic signed [COEF_W-1:0] coef;
        status_t                  status;
        logic [CNT_W-1:0]         count;
    } corr_result_t;

    typedef struct {
        logic [CNT_W-1:0] n;
        logic [SUM_W-1:0] sum_a;
        logic [SUM_W-1:0] sum_b;
        logic [SQ_W-1:0]  sq_a;
        logic [SQ_W-1:0]  sq_b;
        logic [SQ_W-1:0]  sum_ab;
        bit               dropped;
    } pair_sums_t;

    typedef struct {
        logic [VALUE_W-1:0] a;
        logic [VALUE_W-1:0] b;
        bit                 last;
        bit                 typed;
        corr_result_t       res;
    } stim_row_t;

    // Shapes of random sets
    typedef enum int {
        MIX_RANDOM  = 0,
        MIX_RISING  = 1,
        MIX_FALLING = 2,
        MIX_FLAT    = 3,
        MIX_SMALL   = 4
    } mix_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    pcp_pair_if   pairs_if ();
    pcp_result_if results_if ();

    pearson_correlation_pairs_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .pairs   (pairs_if),
        .results (results_if)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    pair_sums_t   sums;
    corr_result_t pending_results [$];
    corr_result_t no_typed;
    int           errors = 0;
    int           items_accepted = 0;
    int           cycles = 0;
    bit           no_idle = 1'b0;

    // Directed sets; typed results are the ones obvious by inspection
    stim_row_t directed_rows [N_ROWS] = '{
        // single pair after reset: zero variance
        '{16'd5,     16'd7,     1'b1, 1'b1, '{0,      ST_ZERO_VAR, 1}},
        // extremes, perfectly correlated
        '{16'd0,     16'd0,     1'b0, 1'b0, '{0,      ST_OK,       0}},
        '{16'hFFFF,  16'hFFFF,  1'b1, 1'b1, '{65536,  ST_OK,       2}},
        // extremes, perfectly anti-correlated
        '{16'd0,     16'hFFFF,  1'b0, 1'b0, '{0,      ST_OK,       0}},
        '{16'hFFFF,  16'd0,     1'b1, 1'b1, '{-65536, ST_OK,       2}},
        // constant first sample
        '{16'hFFFF,  16'd0,     1'b0, 1'b0, '{0,      ST_OK,       0}},
        '{16'hFFFF,  16'hFFFF,  1'b1, 1'b1, '{0,      ST_ZERO_VAR, 2}},
        // all zero
        '{16'd0,     16'd0,     1'b0, 1'b0, '{0,      ST_OK,       0}},
        '{16'd0,     16'd0,     1'b0, 1'b0, '{0,      ST_OK,       0}},
        '{16'd0,     16'd0,     1'b1, 1'b1, '{0,      ST_ZERO_VAR, 3}},
        // small partial correlation
        '{16'd1,     16'd2,     1'b0, 1'b0, '{0,      ST_OK,       0}},
        '{16'd2,     16'd1,     1'b0, 1'b0, '{0,      ST_OK,       0}},
        '{16'd3,     16'd3,     1'b1, 1'b0, '{0,      ST_OK,       0}},
        // alternating bit patterns
        '{16'hAAAA,  16'h5555,  1'b0, 1'b0, '{0,      ST_OK,       0}},
        '{16'h5555,  16'hAAAA,  1'b0, 1'b0, '{0,      ST_OK,       0}},
        '{16'h1234,  16'hFEDC,  1'b1, 1'b0, '{0,      ST_OK,       0}},
        // weak negative trend
        '{16'd100,   16'hFFFF,  1'b0, 1'b0, '{0,      ST_OK,       0}},
        '{16'd200,   16'd0,     1'b0, 1'b0, '{0,      ST_OK,       0}},
        '{16'd300,   16'h8000,  1'b0, 1'b0, '{0,      ST_OK,       0}},
        '{16'd400,   16'd1,     1'b1, 1'b0, '{0,      ST_OK,       0}}
    };

    task automatic flag_mismatch(input string what);
        errors++;
        if (errors <= MAX_PRINTS)
            $display("MISMATCH at %0t: %s", $time, what);
    endtask

    // Correlation of the current set, then the set clears
    function automatic corr_result_t close_set();
        logic [WIDE-1:0] n, var_a, var_b, pos, negp, cov_mag, var_prod, cov_sq, q, trial;
        bit              neg;
        bit              flat;
        corr_result_t    r;
        n       = sums.n;
        var_a   = n * sums.sq_a - sums.sum_a * sums.sum_a;
        var_b   = n * sums.sq_b - sums.sum_b * sums.sum_b;
        pos     = n * sums.sum_ab;
        negp    = sums.sum_a * sums.sum_b;
        neg     = pos < negp;
        cov_mag = neg ? negp - pos : pos - negp;
        flat    = (var_a == 0) || (var_b == 0);
        q       = '0;
        if (n != 0 && !flat)
        begin
            var_prod = var_a * var_b;
            cov_sq   = (cov_mag * cov_mag) << 32;
            // build q one bit at a time from the top; q never exceeds 2^16
            for (int k = FRAC_W; k >= 0; k--)
            begin
                trial = q | (WIDE'(1) << k);
                if (trial * trial * var_prod <= cov_sq)
                    q = trial;
            end
        end
        r.coef = neg ? -q[COEF_W-1:0] : q[COEF_W-1:0];
        if (sums.dropped)
            r.status = ST_OVERFLOW;
        else if (n == 0)
            r.status = ST_NO_PAIRS;
        else if (flat)
            r.status = ST_ZERO_VAR;
        else
            r.status = ST_OK;
        r.count = sums.n;
        sums = '{default: '0};
        return r;
    endfunction

    // Drive one pair until it is taken, then fold it into the running sums
    task automatic send_pair(input logic [VALUE_W-1:0] a, input logic [VALUE_W-1:0] b,
                             input bit last, input bit typed, input corr_result_t typed_res);
        corr_result_t r;
        if (!no_idle)
        begin
            while ($urandom_range(99) < IDLE_PCT)
            begin
                pairs_if.valid <= 1'b0;
                @(posedge clk);
            end
        end
        pairs_if.valid     <= 1'b1;
        pairs_if.value_a   <= a;
        pairs_if.value_b   <= b;
        pairs_if.last_pair <= last;
        @(posedge clk);
        while (!pairs_if.ready)
            @(posedge clk);
        items_accepted++;
        if (sums.n < MAX_PAIRS)
        begin
            sums.n      = sums.n + 1'b1;
            sums.sum_a  = sums.sum_a + a;
            sums.sum_b  = sums.sum_b + b;
            sums.sq_a   = sums.sq_a + SQ_W'(a) * SQ_W'(a);
            sums.sq_b   = sums.sq_b + SQ_W'(b) * SQ_W'(b);
            sums.sum_ab = sums.sum_ab + SQ_W'(a) * SQ_W'(b);
        end
        else
            sums.dropped = 1'b1;
        if (last)
        begin
            r = close_set();
            pending_results.insert(pending_results.size(), typed ? typed_res : r);
        end
    endtask

    task automatic wait_results_drained();
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // One random set: mostly short, now and then up to 300 pairs
    task automatic send_random_set();
        int unsigned        len;
        mix_t               mix;
        logic [VALUE_W-1:0] a;
        logic [VALUE_W-1:0] b;
        logic [VALUE_W-1:0] base;
        len  = ($urandom_range(9) == 0) ? $urandom_range(300, 20) : $urandom_range(12, 1);
        mix  = mix_t'($urandom_range(MIX_SMALL, MIX_RANDOM));
        base = VALUE_W'($urandom);
        for (int unsigned i = 1; i <= len; i++)
        begin
            a = VALUE_W'($urandom);
            b = VALUE_W'($urandom);
            case (mix)
                MIX_RISING:  b = a + VALUE_W'($urandom_range(255));
                MIX_FALLING: b = ~a ^ VALUE_W'($urandom_range(15));
                MIX_FLAT:    a = base;
                MIX_SMALL:
                begin
                    a = VALUE_W'($urandom_range(15));
                    b = VALUE_W'($urandom_range(15));
                end
                default: ;
            endcase
            send_pair(a, b, i == len, 1'b0, no_typed);
        end
    endtask

    // Receiver: random stalls except during the quiet stretch
    always @(posedge clk)
        results_if.ready <= rst_n && (no_idle || $urandom_range(99) >= IDLE_PCT);

    // Result check against the oldest expectation
    always @(posedge clk)
    begin : result_check
        corr_result_t want;
        if (rst_n && results_if.valid && results_if.ready)
        begin
            if (pending_results.size() == 0)
                flag_mismatch("result with nothing pending");
            else
            begin
                want = pending_results.pop_front();
                if (results_if.coefficient !== want.coef)
                    flag_mismatch($sformatf("coefficient %0d, want %0d",
                                            results_if.coefficient, want.coef));
                if (results_if.status !== want.status)
                    flag_mismatch($sformatf("status %0d, want %0d",
                                            results_if.status, want.status));
                if (results_if.pair_count !== want.count)
                    flag_mismatch($sformatf("pair_count %0d, want %0d",
                                            results_if.pair_count, want.count));
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_CAP)
        begin
            $display("pearson_correlation_pairs_unit regression: fail");
            $finish;
        end
    end

    initial
    begin : stimulus
        int unsigned rand_goal;
        pairs_if.valid     = 1'b0;
        pairs_if.value_a   = '0;
        pairs_if.value_b   = '0;
        pairs_if.last_pair = 1'b0;
        results_if.ready   = 1'b0;
        sums               = '{default: '0};
        no_typed           = '{0, ST_OK, 0};

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed sets
        for (int i = 0; i < N_ROWS; i++)
            send_pair(directed_rows[i].a, directed_rows[i].b, directed_rows[i].last,
                      directed_rows[i].typed, directed_rows[i].res);

        // hold the sender until every result is back
        pairs_if.valid <= 1'b0;
        wait_results_drained();
        @(posedge clk);

        // long set of alternating extremes, no idling on either side
        no_idle = 1'b1;
        for (int i = 0; i < LONG_SET; i++)
            send_pair(i[0] ? 16'hFFFF : 16'h0000, i[0] ? 16'hFFFF : 16'h0000,
                      i == LONG_SET - 1, 1'b0, no_typed);
        no_idle = 1'b0;

        // random sets
        rand_goal = items_accepted + RAND_ITEMS;
        while (items_accepted < rand_goal)
            send_random_set();
        pairs_if.valid <= 1'b0;

        wait_results_drained();
        repeat (DRAIN) @(posedge clk);
        if (errors == 0)
            $display("pearson_correlation_pairs_unit regression: pass");
        else
            $display("pearson_correlation_pairs_unit regression: fail");
        $finish;
    end

endmodule
